// File: sv/chte_pkg.sv
// Package for the chained hash table engine: widths, codes, payload types.
package chte_pkg;

   localparam int HashBitsDefault   = 8;
   localparam int SlotFactorDefault = 2;

   localparam logic [63:0] Golden64 = 64'h61C8864680B583EB;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [2:0] ST_FOUND    = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_PRESENT  = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [8:0] position;
      logic [9:0] entry_total;
   } rsp_type;

endpackage

// File: sv/chained_hash_table_engine_core.sv
// Top level of the chained hash table engine: sequencer around head and slot memories.
//
// Usage:
//   req_ channel carries one word {action, key}; rsp_ channel returns one word
//   {status, position, entry_total} per request, in order.
//   Requests are handled one at a time. The bucket hash goes through a 32x32
//   partial-product multiplier that sums three partial products, then the chain
//   is walked one slot at a time (memory read in S_RSLOT, compare in S_CMP).
//   Insert misses additionally scan slots for the lowest free one, a link read
//   and a check per slot, starting from a running hint. An insert behind a
//   nonempty chain writes the tail link in a separate step (MUL step 3).
//   The engine goes back to idle, where it accepts the next word, once it has
//   handed the result to the output register.
//   Clear and reset both start a sweep over the larger memory, the
//   SLOT_FACTOR << BUCKET_BITS slots (512 by default), one entry per cycle,
//   during which no request is accepted. Clear answers after its sweep.
//   A finished result moves into an output register that holds it while the
//   receiver stalls. The engine can accept and work on the next request meanwhile
//   and waits in its response state only while that register is still full.
module chained_hash_table_engine_core #(
   parameter int BUCKET_BITS = chte_pkg::HashBitsDefault,
   parameter int SLOT_FACTOR = chte_pkg::SlotFactorDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  chte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output chte_pkg::rsp_type rsp_data
);

   localparam int BucketCount = 1 << BUCKET_BITS;
   localparam int SlotCount   = SLOT_FACTOR * BucketCount;
   localparam int SW          = $clog2(SlotCount);
   localparam int LW          = SW + 2;
   localparam int CW          = SW + 1;
   // link codes: slot index, END, UNUSED
   localparam logic [LW-1:0] LinkEnd    = {LW{1'b1}};
   localparam logic [LW-1:0] LinkUnused = {{(LW-1){1'b1}}, 1'b0};

   localparam logic [3:0] S_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_HEAD  = 4'd3;
   localparam logic [3:0] S_HDAT  = 4'd4;
   localparam logic [3:0] S_RSLOT = 4'd5;
   localparam logic [3:0] S_CMP   = 4'd6;
   localparam logic [3:0] S_FREE  = 4'd7;
   localparam logic [3:0] S_FCHK  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [LW-1:0] head_mem [BucketCount];
   logic [63:0]   key_mem  [SlotCount];
   logic [LW-1:0] link_mem [SlotCount];

   logic [3:0]          state_ff, state_in;
   logic [1:0]          act_ff, act_in;
   logic [63:0]         key_ff, key_in;
   logic [1:0]          mstep_ff, mstep_in;
   logic [63:0]         hacc_ff, hacc_in;
   logic [BUCKET_BITS-1:0] bkt_ff, bkt_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       prev_ff, prev_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       walk_ff, walk_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic [SW-1:0]       hint_ff, hint_in;
   logic                rv_ff, rv_in;
   chte_pkg::rsp_type   rsp_ff, rsp_in;
   chte_pkg::rsp_type   out_ff, out_in;

   // memory ports
   logic                 h_we, k_we, l_we;
   logic [BUCKET_BITS-1:0] h_waddr, h_raddr;
   logic [LW-1:0]        h_wdata, h_rdata_ff;
   logic [SW-1:0]        k_waddr, l_waddr, s_raddr;
   logic [63:0]          k_rdata_ff;
   logic [LW-1:0]        l_wdata, l_rdata_ff;

   always_ff @(posedge clock) begin
      if (h_we) head_mem[h_waddr] <= h_wdata;
      h_rdata_ff <= head_mem[h_raddr];
      if (k_we) key_mem[k_waddr] <= key_ff;
      k_rdata_ff <= key_mem[s_raddr];
      if (l_we) link_mem[l_waddr] <= l_wdata;
      l_rdata_ff <= link_mem[s_raddr];
   end

   // 32x32 partial products of key * golden, low 64 bits only
   logic [31:0] ma, mb;
   logic [63:0] pp, pp_sh;
   always_comb begin
      ma = key_ff[31:0];
      mb = chte_pkg::Golden64[31:0];
      pp_sh = '0;
      case (mstep_ff)
         2'd0: begin ma = key_ff[31:0];  mb = chte_pkg::Golden64[31:0];  end
         2'd1: begin ma = key_ff[63:32]; mb = chte_pkg::Golden64[31:0];  end
         2'd2: begin ma = key_ff[31:0];  mb = chte_pkg::Golden64[63:32]; end
         default: begin ma = '0; mb = '0; end
      endcase
      pp = 64'(ma) * 64'(mb);
      pp_sh = (mstep_ff == 2'd0) ? pp : {pp[31:0], 32'd0};
   end

   logic cur_valid;
   assign cur_valid = (cur_ff[LW-1:SW] == 2'b00) && (cur_ff < LW'(SlotCount));

   always_comb begin
      state_in = state_ff; act_in = act_ff; key_in = key_ff;
      mstep_in = mstep_ff; hacc_in = hacc_ff; bkt_in = bkt_ff;
      cur_in = cur_ff; prev_in = prev_ff; cnt_in = cnt_ff;
      walk_in = walk_ff; scan_in = scan_ff; hint_in = hint_ff;
      rv_in = rv_ff; rsp_in = rsp_ff; out_in = out_ff;
      h_we = 1'b0; h_waddr = scan_ff[BUCKET_BITS-1:0]; h_wdata = LinkEnd;
      h_raddr = bkt_ff;
      k_we = 1'b0; k_waddr = scan_ff[SW-1:0];
      l_we = 1'b0; l_waddr = scan_ff[SW-1:0]; l_wdata = LinkUnused;
      s_raddr = cur_ff[SW-1:0];
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            l_we = 1'b1;
            if (scan_ff < CW'(BucketCount)) h_we = 1'b1;
            if (scan_ff == CW'(SlotCount - 1)) begin
               cnt_in = '0; hint_in = '0;
               if (act_ff == chte_pkg::ACT_CLEAR) begin
                  rsp_in = '{chte_pkg::ST_CLEARED, 9'd0, 10'd0};
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
            scan_in = scan_ff + 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in = req_data.action; key_in = req_data.key;
               scan_in = '0;
               if (req_data.action == chte_pkg::ACT_CLEAR) state_in = S_SWEEP;
               else begin mstep_in = '0; hacc_in = '0; state_in = S_MUL; end
            end
         end
         S_MUL: begin
            hacc_in = hacc_ff + pp_sh;
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 2'd2) state_in = S_HEAD;
         end
         S_HEAD: begin
            bkt_in = hacc_ff[63 -: BUCKET_BITS];
            if (act_ff == chte_pkg::ACT_INSERT && cnt_ff >= CW'(SlotCount)) begin
               rsp_in = '{chte_pkg::ST_FULL, 9'd0, 10'(cnt_ff)};
               state_in = S_RESP;
            end else state_in = S_HDAT;
         end
         S_HDAT: begin
            // h_raddr = bkt_ff, data arrives next cycle
            state_in = S_RSLOT;
            prev_in = LinkEnd; walk_in = '0;
            cur_in = LinkEnd;
         end
         S_RSLOT: begin
            if (cur_ff == LinkEnd && prev_ff == LinkEnd && walk_ff == '0) begin
               // first slot comes from the head read: address the slot memories with it
               cur_in = h_rdata_ff;
               s_raddr = h_rdata_ff[SW-1:0];
            end
            walk_in = walk_ff + 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!cur_valid || walk_ff > CW'(SlotCount)) begin
               if (act_ff == chte_pkg::ACT_INSERT) begin
                  scan_in = CW'(hint_ff); state_in = S_FREE;
               end else begin
                  rsp_in = '{chte_pkg::ST_NOTFOUND, 9'd0, 10'(cnt_ff)};
                  state_in = S_RESP;
               end
            end else if (k_rdata_ff == key_ff) begin
               case (act_ff)
                  chte_pkg::ACT_INSERT:
                     rsp_in = '{chte_pkg::ST_PRESENT, 9'(cur_ff), 10'(cnt_ff)};
                  chte_pkg::ACT_REMOVE: begin
                     if (prev_ff == LinkEnd) begin
                        h_we = 1'b1; h_waddr = bkt_ff; h_wdata = l_rdata_ff;
                     end else begin
                        l_we = 1'b1; l_waddr = prev_ff[SW-1:0]; l_wdata = l_rdata_ff;
                     end
                     cnt_in = cnt_ff - 1'b1;
                     if (cur_ff[SW-1:0] < hint_ff) hint_in = cur_ff[SW-1:0];
                     rsp_in = '{chte_pkg::ST_FOUND, 9'(cur_ff), 10'(cnt_ff - 1'b1)};
                  end
                  default:
                     rsp_in = '{chte_pkg::ST_FOUND, 9'(cur_ff), 10'(cnt_ff)};
               endcase
               if (act_ff == chte_pkg::ACT_REMOVE) scan_in = CW'(cur_ff[SW-1:0]);
               state_in = (act_ff == chte_pkg::ACT_REMOVE) ? S_FCHK : S_RESP;
            end else begin
               prev_in = cur_ff; cur_in = l_rdata_ff;
               state_in = S_RSLOT;
            end
         end
         S_FREE: begin
            // read link at scan position
            s_raddr = scan_ff[SW-1:0];
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (act_ff == chte_pkg::ACT_REMOVE) begin
               l_we = 1'b1; l_waddr = scan_ff[SW-1:0]; l_wdata = LinkUnused;
               state_in = S_RESP;
            end else if (l_rdata_ff == LinkUnused) begin
               k_we = 1'b1; k_waddr = scan_ff[SW-1:0];
               l_we = 1'b1; l_waddr = scan_ff[SW-1:0]; l_wdata = LinkEnd;
               if (prev_ff == LinkEnd) begin
                  h_we = 1'b1; h_waddr = bkt_ff; h_wdata = LW'(scan_ff[SW-1:0]);
               end
               cnt_in = cnt_ff + 1'b1;
               hint_in = scan_ff[SW-1:0] + 1'b1;
               rsp_in = '{chte_pkg::ST_INSERTED, 9'(scan_ff[SW-1:0]),
                          10'(cnt_ff + 1'b1)};
               // tail link written in a separate cycle when chain was nonempty
               state_in = (prev_ff == LinkEnd) ? S_RESP : S_IDLE;
               if (prev_ff != LinkEnd) begin
                  cur_in = LW'(scan_ff[SW-1:0]);
                  state_in = S_MUL; mstep_in = 2'd3;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
               state_in = S_FREE;
            end
         end
         S_RESP: begin
            // hand the result to the output register once it is free
            if (!rv_ff || rsp_ready) begin
               out_in = rsp_ff; rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // tail link fixup, reusing MUL with step 3
      if (state_ff == S_MUL && mstep_ff == 2'd3) begin
         l_we = 1'b1; l_waddr = prev_ff[SW-1:0]; l_wdata = cur_ff;
         hacc_in = hacc_ff; state_in = S_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP; scan_ff <= '0; act_ff <= chte_pkg::ACT_LOOKUP;
         rv_ff <= 1'b0; cnt_ff <= '0; hint_ff <= '0;
      end else begin
         state_ff <= state_in; scan_ff <= scan_in; act_ff <= act_in;
         rv_ff <= rv_in; cnt_ff <= cnt_in; hint_ff <= hint_in;
      end
      key_ff <= key_in; mstep_ff <= mstep_in; hacc_ff <= hacc_in; bkt_ff <= bkt_in;
      cur_ff <= cur_in; prev_ff <= prev_in; walk_ff <= walk_in; rsp_ff <= rsp_in;
      out_ff <= out_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = out_ff;

   ap_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(SlotCount)) else $error("count beyond slot count");
   ap_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   ap_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   ap_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("response changed");

endmodule

// File: verif/tb.sv
// Testbench for the chained hash table engine: random and directed table operations.
`timescale 1ns / 1ps

module tb;

   localparam int BucketCount = 1 << chte_pkg::HashBitsDefault;
   localparam int SlotCount   = chte_pkg::SlotFactorDefault * BucketCount;
   localparam int LinkEnd     = -1;
   localparam int LinkFree    = -2;
   localparam int IdleLimit   = 20000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   chte_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   chte_pkg::rsp_type rsp_data;

   chained_hash_table_engine_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // shadow table
   int          head_of[BucketCount];
   logic [63:0] key_of[SlotCount];
   int          link_of[SlotCount];
   int          used_slots;
   logic [63:0] live_keys[$];

   chte_pkg::req_type pending_words[$];
   chte_pkg::rsp_type expected_rsp[$];
   int      error_count;
   int      accepted_count;
   int      result_count;
   int      idle_cycles;
   bit      calm_phase;
   bit      req_taken;
   int      hold_left;
   int      rsp_gap;
   int      req_gap;

   function automatic int bucket_index(logic [63:0] k);
      logic [63:0] prod;
      prod = k * chte_pkg::Golden64;
      return int'(prod >> (64 - chte_pkg::HashBitsDefault));
   endfunction

   function automatic void empty_table();
      foreach (head_of[i]) head_of[i] = LinkEnd;
      foreach (link_of[i]) link_of[i] = LinkFree;
      used_slots = 0;
      live_keys.delete();
   endfunction

   // walk the chain; returns slot or LinkEnd, prev gets predecessor
   function automatic int chain_search(logic [63:0] k, output int prev);
      int cur;
      cur = head_of[bucket_index(k)];
      prev = LinkEnd;
      while (cur >= 0) begin
         if (key_of[cur] == k) return cur;
         prev = cur;
         cur = link_of[cur];
      end
      return LinkEnd;
   endfunction

   function automatic chte_pkg::rsp_type table_result(chte_pkg::req_type w);
      chte_pkg::rsp_type r;
      int s, prev, fr;
      r = '0;
      r.status = chte_pkg::ST_NOTFOUND;
      case (w.action)
         chte_pkg::ACT_CLEAR: begin
            empty_table();
            r.status = chte_pkg::ST_CLEARED;
         end
         chte_pkg::ACT_LOOKUP: begin
            s = chain_search(w.key, prev);
            if (s >= 0) begin
               r.status = chte_pkg::ST_FOUND;
               r.position = s[8:0];
            end
         end
         chte_pkg::ACT_REMOVE: begin
            s = chain_search(w.key, prev);
            if (s >= 0) begin
               if (prev >= 0) link_of[prev] = link_of[s];
               else head_of[bucket_index(w.key)] = link_of[s];
               link_of[s] = LinkFree;
               used_slots--;
               foreach (live_keys[i])
                  if (live_keys[i] == w.key) begin
                     live_keys.delete(i);
                     break;
                  end
               r.status = chte_pkg::ST_FOUND;
               r.position = s[8:0];
            end
         end
         default: begin
            if (used_slots >= SlotCount) r.status = chte_pkg::ST_FULL;
            else begin
               s = chain_search(w.key, prev);
               if (s >= 0) begin
                  r.status = chte_pkg::ST_PRESENT;
                  r.position = s[8:0];
               end else begin
                  fr = LinkEnd;
                  for (int i = 0; i < SlotCount; i++)
                     if (link_of[i] == LinkFree) begin
                        fr = i;
                        break;
                     end
                  key_of[fr] = w.key;
                  link_of[fr] = LinkEnd;
                  if (prev >= 0) link_of[prev] = fr;
                  else head_of[bucket_index(w.key)] = fr;
                  used_slots++;
                  live_keys.push_back(w.key);
                  r.status = chte_pkg::ST_INSERTED;
                  r.position = fr[8:0];
               end
            end
         end
      endcase
      r.entry_total = used_slots[9:0];
      return r;
   endfunction

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   // keys that share a small pool so chains grow and collide
   function automatic logic [63:0] pool_key();
      return 64'(($urandom_range(0, 47)) * 64'h9E37_79B9) ^ 64'hF0F0_0000_0000_0000;
   endfunction

   function automatic void queue_word(logic [1:0] a, logic [63:0] k);
      chte_pkg::req_type w;
      w.action = a;
      w.key = k;
      pending_words.push_back(w);
   endfunction

   function automatic void queue_random();
      int pick;
      logic [1:0] a;
      logic [63:0] k;
      pick = $urandom_range(0, 99);
      if (pick < 45) a = chte_pkg::ACT_INSERT;
      else if (pick < 70) a = chte_pkg::ACT_LOOKUP;
      else if (pick < 99) a = chte_pkg::ACT_REMOVE;
      else a = chte_pkg::ACT_CLEAR;
      pick = $urandom_range(0, 2);
      if (pick == 0) k = rand_key();
      else if (pick == 1) k = pool_key();
      else k = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 26'h0, 6'($urandom_range(0, 63))};
      queue_word(a, k);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0
                      && (calm_phase || $urandom_range(0, 9) != 0)) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            if (pending_words.size() > 0) req_gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
         end
         req_taken = 1'b0;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            // predict in acceptance order
            expected_rsp.push_back(table_result(req_data));
            accepted_count++;
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_rsp.size() == 0) begin
               error_count++;
               $display("%0t: expected no result, actual %p", $realtime, rsp_data);
            end else begin
               chte_pkg::rsp_type e;
               e = expected_rsp.pop_front();
               if (e.status !== rsp_data.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           e.status, rsp_data.status);
               end
               if (e.position !== rsp_data.position) begin
                  error_count++;
                  $display("%0t: position expected %0d actual %0d", $realtime,
                           e.position, rsp_data.position);
               end
               if (e.entry_total !== rsp_data.entry_total) begin
                  error_count++;
                  $display("%0t: entry_total expected %0d actual %0d", $realtime,
                           e.entry_total, rsp_data.entry_total);
               end
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no progress for %0d cycles", IdleLimit);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic bit all_done();
      return pending_words.size() == 0 && expected_rsp.size() == 0 && !req_valid;
   endfunction

   initial begin
      logic [63:0] k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      error_count = 0;
      accepted_count = 0;
      result_count = 0;
      idle_cycles = 0;
      calm_phase = 1'b0;
      req_taken = 1'b0;
      hold_left = 0;
      rsp_gap = 0;
      req_gap = 0;
      empty_table();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: misses on empty table, extreme keys, duplicates, removes, clear
      queue_word(chte_pkg::ACT_LOOKUP, 64'h0);
      queue_word(chte_pkg::ACT_REMOVE, '1);
      queue_word(chte_pkg::ACT_INSERT, 64'h0);
      queue_word(chte_pkg::ACT_INSERT, '1);
      queue_word(chte_pkg::ACT_INSERT, 64'h0);
      queue_word(chte_pkg::ACT_LOOKUP, '1);
      queue_word(chte_pkg::ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_word(chte_pkg::ACT_INSERT, 64'h5555_5555_5555_5555);
      queue_word(chte_pkg::ACT_REMOVE, 64'h0);
      queue_word(chte_pkg::ACT_LOOKUP, 64'h0);
      queue_word(chte_pkg::ACT_INSERT, 64'h8000_0000_0000_0000);
      queue_word(chte_pkg::ACT_REMOVE, 64'h5555_5555_5555_5555);
      queue_word(chte_pkg::ACT_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_word(chte_pkg::ACT_CLEAR, '1);
      queue_word(chte_pkg::ACT_LOOKUP, '1);
      while (!all_done()) @(posedge clock);

      // long receiver hold while the sender keeps offering
      for (int i = 0; i < 40; i++) queue_word(chte_pkg::ACT_INSERT, pool_key());
      hold_left = 300;
      while (!all_done()) @(posedge clock);

      // fill to the top, hit full, then chain removes and reinserts
      for (int i = 0; i < SlotCount + 4; i++) queue_word(chte_pkg::ACT_INSERT, rand_key());
      for (int i = 0; i < 30; i++) begin
         k = live_keys[$urandom_range(0, live_keys.size() - 1)];
         queue_word(chte_pkg::ACT_REMOVE, k);
         queue_word(chte_pkg::ACT_INSERT, rand_key());
         queue_word(chte_pkg::ACT_INSERT, rand_key());
         queue_word(chte_pkg::ACT_LOOKUP, k);
      end
      while (!all_done()) @(posedge clock);
      queue_word(chte_pkg::ACT_CLEAR, 64'h0);

      // random mix
      for (int i = 0; i < 1300; i++) begin
         if (i == 650) begin
            while (!all_done()) @(posedge clock);
         end
         if (live_keys.size() > 0 && $urandom_range(0, 3) == 0)
            queue_word($urandom_range(0, 1) ? chte_pkg::ACT_REMOVE : chte_pkg::ACT_LOOKUP,
                       live_keys[$urandom_range(0, live_keys.size() - 1)]);
         else queue_random();
      end
      while (pending_words.size() >= 100) @(posedge clock);
      calm_phase = 1'b1;
      while (!all_done()) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d requests and %0d results: hits, misses, duplicates,", accepted_count,
               result_count);
      $display("full table, chain unlinks, clears and long output stalls");
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
